// ===== hw/rtl/qpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion pose update package
// Shared widths, word types, the Hamilton product term table and the
// control structures between the top level and the divider.
// ----------------------------------------------------------------------------
package qpu_pkg;

    localparam int COMP_BITS = 32;
    localparam int FRAC_BITS = COMP_BITS - 2;
    localparam int ACC_BITS  = 2 * COMP_BITS + 2;
    localparam int WIDE_BITS = 2 * COMP_BITS;

    localparam logic signed [COMP_BITS-1:0] ONE_VALUE = 32'sh4000_0000;

    typedef logic signed [COMP_BITS-1:0] comp_t;

    // Input word: kind zero restarts the pose, kind one applies an increment.
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    typedef struct packed {
        logic  kind;
        comp_t delta_w;
        comp_t delta_x;
        comp_t delta_y;
        comp_t delta_z;
    } in_word_t;

    typedef struct packed {
        comp_t pose_w;
        comp_t pose_x;
        comp_t pose_y;
        comp_t pose_z;
        logic  zero_length;
    } out_word_t;

    // One term of the Hamilton product: which pose and increment component
    // are multiplied, and whether the product is subtracted.
    typedef struct packed {
        logic [1:0] p_idx;
        logic [1:0] d_idx;
        logic       neg;
    } term_t;

    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] num;
        logic [COMP_BITS-1:0] den;
    } div_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [COMP_BITS-1:0] quot;
    } div_st_t;

    // Term table: the upper two bits pick the result component, the lower
    // two the term within its sum.
    function automatic term_t term_sel(input logic [3:0] k);
        term_t t;
        case (k)
            4'd0:    t = '{p_idx: 2'd0, d_idx: 2'd0, neg: 1'b0};
            4'd1:    t = '{p_idx: 2'd1, d_idx: 2'd1, neg: 1'b1};
            4'd2:    t = '{p_idx: 2'd2, d_idx: 2'd2, neg: 1'b1};
            4'd3:    t = '{p_idx: 2'd3, d_idx: 2'd3, neg: 1'b1};
            4'd4:    t = '{p_idx: 2'd0, d_idx: 2'd1, neg: 1'b0};
            4'd5:    t = '{p_idx: 2'd1, d_idx: 2'd0, neg: 1'b0};
            4'd6:    t = '{p_idx: 2'd2, d_idx: 2'd3, neg: 1'b0};
            4'd7:    t = '{p_idx: 2'd3, d_idx: 2'd2, neg: 1'b1};
            4'd8:    t = '{p_idx: 2'd0, d_idx: 2'd2, neg: 1'b0};
            4'd9:    t = '{p_idx: 2'd1, d_idx: 2'd3, neg: 1'b1};
            4'd10:   t = '{p_idx: 2'd2, d_idx: 2'd0, neg: 1'b0};
            4'd11:   t = '{p_idx: 2'd3, d_idx: 2'd1, neg: 1'b0};
            4'd12:   t = '{p_idx: 2'd0, d_idx: 2'd3, neg: 1'b0};
            4'd13:   t = '{p_idx: 2'd1, d_idx: 2'd2, neg: 1'b0};
            4'd14:   t = '{p_idx: 2'd2, d_idx: 2'd1, neg: 1'b1};
            default: t = '{p_idx: 2'd3, d_idx: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/qpu_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion pose update channels
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface qpu_in_if;
    import qpu_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface qpu_out_if;
    import qpu_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== hw/rtl/qpu_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion pose update divider
// Restoring divider, one quotient bit a cycle, for quotients below 2^32.
// ----------------------------------------------------------------------------
module qpu_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  qpu_pkg::div_ctl_t ctl,
    output qpu_pkg::div_st_t  st
);
    import qpu_pkg::*;

    logic [COMP_BITS-1:0] rem_reg;
    logic [COMP_BITS-1:0] dq_reg;
    logic [COMP_BITS-1:0] den_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;

    logic [COMP_BITS:0]   trial;
    logic                 fits;
    logic [COMP_BITS:0]   diff;
    logic [COMP_BITS-1:0] rem_next;
    logic [COMP_BITS-1:0] dq_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[COMP_BITS-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[COMP_BITS-1:0] : trial[COMP_BITS-1:0];
        dq_next  = {dq_reg[COMP_BITS-2:0], fits};
    end

    // The upper dividend half is already below the divisor, so it seeds the remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= ctl.num[WIDE_BITS-1:COMP_BITS];
            dq_reg   <= ctl.num[COMP_BITS-1:0];
            den_reg  <= ctl.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign st.done = busy_reg && (cnt_reg == 5'd31);
    assign st.quot = dq_next;

endmodule

// ===== hw/rtl/quaternion_pose_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion pose update
// Keeps a pose quaternion, multiplies it by increments and normalises it.
// ----------------------------------------------------------------------------
// Usage:
// The update channel takes one word at a time. Kind zero sets the pose back
// to identity; kind one multiplies the pose on the right by the increment,
// scales the product to unit length, stores it and reports it. Every word
// gives exactly one result word on the result channel, carrying the pose
// after the word and a zero length flag when the product was zero.
// A restart passes from the accepted word straight to the result register.
// An update takes the word, forms the sixteen products on the shared 32 by
// 32 multiplier, checks for a zero product, normalises by a one-bit-a-cycle
// shift, forms the squares, takes the bit-wise square root, runs the
// restoring divider once per component and loads the result register.
// Update ready is high only while the block is idle. A finished result
// waits in the output register while the receiver stalls; the block holds
// the next result until the register is free. Reset sets the pose to
// identity and empties the output register.
// ----------------------------------------------------------------------------
module quaternion_pose_update (
    input  logic       clk,
    input  logic       rst_n,
    qpu_in_if.sink     update,
    qpu_out_if.source  result
);
    import qpu_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FIN   = 11'b000_0000_0010,
        S_PMUL  = 11'b000_0000_0100,
        S_PACC  = 11'b000_0000_1000,
        S_POST  = 11'b000_0001_0000,
        S_NORM  = 11'b000_0010_0000,
        S_SMUL  = 11'b000_0100_0000,
        S_SACC  = 11'b000_1000_0000,
        S_ROOT  = 11'b001_0000_0000,
        S_DLOAD = 11'b010_0000_0000,
        S_DWAIT = 11'b100_0000_0000
    } state_t;

    localparam logic signed [ACC_BITS-1:0] BIG_LIMIT = 66'sh1000_0000_0000_0000;
    localparam logic [WIDE_BITS-1:0]       ROOT_BIT0 = 64'h4000_0000_0000_0000;

    state_t                     state_reg;
    logic [4:0]                 cnt_reg;
    comp_t                      pose_reg  [4];
    comp_t                      delta_reg [4];
    logic signed [ACC_BITS-1:0] acc_reg   [4];
    logic [WIDE_BITS-1:0]       mag_reg   [4];
    logic                       neg_reg   [4];
    logic signed [WIDE_BITS-1:0] prod_reg;
    logic [WIDE_BITS-1:0]       s_reg;
    logic [WIDE_BITS-1:0]       r_reg;
    logic [WIDE_BITS-1:0]       b_reg;
    logic [COMP_BITS-1:0]       len_reg;
    logic                       flag_reg;
    logic                       out_valid_reg;
    out_word_t                  out_word_reg;

    term_t                      term;
    comp_t                      mul_a;
    comp_t                      mul_b;
    logic signed [ACC_BITS-1:0] prod_ext;
    logic signed [ACC_BITS-1:0] acc_base;
    logic signed [ACC_BITS-1:0] c_v   [4];
    logic signed [ACC_BITS-1:0] v_v   [4];
    logic        [ACC_BITS-1:0] m_v   [4];
    logic                       big;
    logic                       all_zero;
    logic                       any_hi;
    logic                       all_lo;
    logic [WIDE_BITS-1:0]       rb;
    logic                       root_ge;
    logic [WIDE_BITS-1:0]       r_next;
    comp_t                      q_signed;
    div_ctl_t                   div_ctl;
    div_st_t                    div_st;

    // Shared multiplier operands: product terms first, then the squares.
    always_comb
    begin
        term = term_sel(cnt_reg[3:0]);
        if (state_reg == S_PMUL)
        begin
            mul_a = pose_reg[term.p_idx];
            mul_b = delta_reg[term.d_idx];
        end
        else
        begin
            mul_a = signed'(mag_reg[cnt_reg[1:0]][COMP_BITS-1:0]);
            mul_b = signed'(mag_reg[cnt_reg[1:0]][COMP_BITS-1:0]);
        end
        prod_ext = {{(ACC_BITS-WIDE_BITS){prod_reg[WIDE_BITS-1]}}, prod_reg};
        acc_base = (cnt_reg[1:0] == 2'd0) ? '0 : acc_reg[cnt_reg[3:2]];
    end

    // Product scale choice, signs and magnitudes of the four components.
    always_comb
    begin
        big      = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            c_v[i] = acc_reg[i] >>> 2;
            if (c_v[i] >= BIG_LIMIT || c_v[i] <= -BIG_LIMIT)
            begin
                big = 1'b1;
            end
            if (acc_reg[i] != '0)
            begin
                all_zero = 1'b0;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            v_v[i] = big ? c_v[i] : acc_reg[i];
            m_v[i] = v_v[i][ACC_BITS-1] ? ACC_BITS'(-v_v[i]) : ACC_BITS'(v_v[i]);
        end
    end

    // Normalising window tests on the largest magnitude.
    always_comb
    begin
        any_hi = 1'b0;
        all_lo = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (mag_reg[i][WIDE_BITS-1:COMP_BITS-1] != '0)
            begin
                any_hi = 1'b1;
            end
            if (mag_reg[i][WIDE_BITS-1:COMP_BITS-2] != '0)
            begin
                all_lo = 1'b0;
            end
        end
    end

    // One step of the bit-wise square root.
    always_comb
    begin
        rb      = r_reg + b_reg;
        root_ge = s_reg >= rb;
        r_next  = root_ge ? (r_reg >> 1) + b_reg : r_reg >> 1;
    end

    // Divider request: rounded quotient of the magnitude over the length.
    always_comb
    begin
        div_ctl.start = (state_reg == S_DLOAD);
        div_ctl.num   = (mag_reg[cnt_reg[1:0]] << FRAC_BITS)
                        + {{(COMP_BITS+1){1'b0}}, len_reg[COMP_BITS-1:1]};
        div_ctl.den   = len_reg;
        q_signed      = neg_reg[cnt_reg[1:0]] ? -signed'(div_st.quot)
                                               : signed'(div_st.quot);
    end

    qpu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .st    (div_st)
    );

    // Shared multiplier with its output register.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pose_reg[0]   <= ONE_VALUE;
            pose_reg[1]   <= '0;
            pose_reg[2]   <= '0;
            pose_reg[3]   <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (update.valid)
                    begin
                        cnt_reg <= '0;
                        if (update.word.kind == KIND_RESTART)
                        begin
                            pose_reg[0] <= ONE_VALUE;
                            pose_reg[1] <= '0;
                            pose_reg[2] <= '0;
                            pose_reg[3] <= '0;
                            flag_reg    <= 1'b0;
                            state_reg   <= S_FIN;
                        end
                        else
                        begin
                            delta_reg[0] <= update.word.delta_w;
                            delta_reg[1] <= update.word.delta_x;
                            delta_reg[2] <= update.word.delta_y;
                            delta_reg[3] <= update.word.delta_z;
                            state_reg    <= S_PMUL;
                        end
                    end
                end
                S_PMUL:
                begin
                    state_reg <= S_PACC;
                end
                S_PACC:
                begin
                    acc_reg[cnt_reg[3:2]] <= term.neg ? acc_base - prod_ext
                                                      : acc_base + prod_ext;
                    cnt_reg <= cnt_reg + 5'd1;
                    state_reg <= (cnt_reg == 5'd15) ? S_POST : S_PMUL;
                end
                S_POST:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        mag_reg[i] <= m_v[i][WIDE_BITS-1:0];
                        neg_reg[i] <= v_v[i][ACC_BITS-1];
                    end
                    if (all_zero)
                    begin
                        flag_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (any_hi)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end
                    else if (all_lo)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        s_reg     <= '0;
                        state_reg <= S_SMUL;
                    end
                end
                S_SMUL:
                begin
                    state_reg <= S_SACC;
                end
                S_SACC:
                begin
                    s_reg   <= s_reg + unsigned'(prod_reg);
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg   <= '0;
                        r_reg     <= '0;
                        b_reg     <= ROOT_BIT0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 5'd1;
                        state_reg <= S_SMUL;
                    end
                end
                S_ROOT:
                begin
                    if (root_ge)
                    begin
                        s_reg <= s_reg - rb;
                    end
                    r_reg   <= r_next;
                    b_reg   <= b_reg >> 2;
                    if (cnt_reg == 5'd31)
                    begin
                        len_reg   <= (r_next[COMP_BITS-1:0] == '0) ? COMP_BITS'(1)
                                                                 : r_next[COMP_BITS-1:0];
                        cnt_reg   <= '0;
                        state_reg <= S_DLOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DLOAD:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_st.done)
                    begin
                        pose_reg[cnt_reg[1:0]] <= q_signed;
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'd3)
                        begin
                            flag_reg  <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_DLOAD;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && (!out_valid_reg || result.ready))
        begin
            out_word_reg.pose_w      <= pose_reg[0];
            out_word_reg.pose_x      <= pose_reg[1];
            out_word_reg.pose_y      <= pose_reg[2];
            out_word_reg.pose_z      <= pose_reg[3];
            out_word_reg.zero_length <= flag_reg;
        end
    end

    assign update.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.word  = out_word_reg;

`ifndef SYNTHESIS
    // A restart word goes straight to the result stage.
    a_restart_fin: assert property (@(posedge clk) disable iff (!rst_n)
        update.valid && update.ready && update.word.kind == KIND_RESTART
        |=> state_reg == S_FIN)
        else $error("restart word did not go to the result stage");

    // After normalisation every magnitude lies below 2^31.
    a_norm_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SMUL |->
        mag_reg[0][WIDE_BITS-1:COMP_BITS-1] == '0 &&
        mag_reg[1][WIDE_BITS-1:COMP_BITS-1] == '0 &&
        mag_reg[2][WIDE_BITS-1:COMP_BITS-1] == '0 &&
        mag_reg[3][WIDE_BITS-1:COMP_BITS-1] == '0)
        else $error("magnitude left the normalising window");

    // The length of a normalised product is at least one.
    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DLOAD |-> len_reg >= 32'h4000_0000)
        else $error("square root below the normalised floor");

    // A normalised component never exceeds one.
    a_quot_one: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> div_st.quot <= unsigned'(ONE_VALUE))
        else $error("normalised component above one");
`endif

endmodule
